// ===== src/gld_pkg.sv =====
// ----------------------------------------------------------------------------
// gld_pkg
// shared types and constants of the gps log record deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gld_pkg;

  // record layout
  localparam int unsigned GLD_RECORD_LEN     = 21;
  localparam int unsigned GLD_HDR_LEN        = 3;
  localparam int unsigned GLD_SPACER_LEN_DEF = 6;
  localparam int unsigned GLD_POS_W          = 5;

  // record byte positions
  localparam int unsigned GLD_POS_HOUR     = 3;
  localparam int unsigned GLD_POS_MINUTE   = 4;
  localparam int unsigned GLD_POS_SECOND   = 5;
  localparam int unsigned GLD_POS_DAY      = 6;
  localparam int unsigned GLD_POS_MONTH    = 7;
  localparam int unsigned GLD_POS_YEAR     = 8;
  localparam int unsigned GLD_POS_SPEED    = 9;
  localparam int unsigned GLD_POS_LAT      = 11;
  localparam int unsigned GLD_POS_LON      = 15;
  localparam int unsigned GLD_POS_CONTACTS = 19;

  // header bytes
  localparam logic [7:0] GLD_SYNC_A = 8'd255;
  localparam logic [7:0] GLD_SYNC_B = 8'd170;

  // scaling
  localparam int unsigned GLD_YEAR_BASE    = 2000;
  localparam int unsigned GLD_KNOT_MILLI   = 1852;
  localparam int unsigned GLD_MIN_SCALE_HI = 10000;
  localparam int unsigned GLD_MIN_SCALE_LO = 100;
  localparam int unsigned GLD_USEC_PER_DEG = 1000000;
  // floor(x*5/3) = (x * 5 * ceil(2^25/3)) >> 25 for 5*x < 2^24
  localparam int unsigned GLD_DIV3X5_MAGIC = 55924055;
  localparam int unsigned GLD_DIV3_SHIFT   = 25;

  localparam int unsigned GLD_MINS_W  = 22;
  localparam int unsigned GLD_FRAC_W  = 23;
  localparam int unsigned GLD_COORD_W = 29;
  localparam int unsigned GLD_YEAR_W  = 12;
  localparam int unsigned GLD_SPEED_W = 19;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_SPACER = 2'd2,
    MODE_HUNT   = 2'd3
  } gld_mode_e;

  typedef enum logic [1:0] {
    GLD_ST_OK       = 2'd0,
    GLD_ST_CHECKSUM = 2'd1,
    GLD_ST_FRAMING  = 2'd2,
    GLD_ST_END      = 2'd3
  } gld_status_e;

  typedef struct packed {
    gld_status_e              status;
    logic [7:0]               contacts;
    logic [GLD_COORD_W-1:0]   lon_microdeg;
    logic [GLD_COORD_W-1:0]   lat_microdeg;
    logic [GLD_SPEED_W-1:0]   speed_milli_kmh;
    logic [GLD_YEAR_W-1:0]    year;
    logic [7:0]               month;
    logic [7:0]               day;
    logic [7:0]               second;
    logic [7:0]               minute;
    logic [7:0]               hour;
  } gld_result_t;

  // expected header byte at a position 0..2
  function automatic logic [7:0] gld_hdr_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd1:    val = GLD_SYNC_B;
      default: val = GLD_SYNC_A;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/gld_coord.sv =====
// ----------------------------------------------------------------------------
// gld_coord
// builds one coordinate in microdegrees from four record bytes as they arrive
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gld_coord #(
  parameter int unsigned DEG_POS = gld_pkg::GLD_POS_LAT
) (
  input  var logic                                clk_i,
  input  var logic                                byte_en_i,
  input  var logic [gld_pkg::GLD_POS_W-1:0]       pos_i,
  input  var logic [7:0]                          byte_i,
  output var logic [gld_pkg::GLD_COORD_W-1:0]     coord_o
);
  import gld_pkg::*;

  localparam logic [GLD_POS_W-1:0] PosDeg  = GLD_POS_W'(DEG_POS);
  localparam logic [GLD_POS_W-1:0] PosMinA = GLD_POS_W'(DEG_POS + 1);
  localparam logic [GLD_POS_W-1:0] PosMinB = GLD_POS_W'(DEG_POS + 2);
  localparam logic [GLD_POS_W-1:0] PosMinC = GLD_POS_W'(DEG_POS + 3);
  localparam logic [GLD_POS_W-1:0] PosFrac = GLD_POS_W'(DEG_POS + 4);
  localparam int unsigned ProdW = GLD_MINS_W + 26;

  logic [7:0]            deg_q;
  logic [GLD_MINS_W-1:0] mins_q;
  logic [GLD_FRAC_W-1:0] frac_q;
  logic [ProdW-1:0]      prod;

  // minutes times 100/60, truncated, via reciprocal multiply
  assign prod = ProdW'(mins_q) * ProdW'(GLD_DIV3X5_MAGIC);

  always_ff @(posedge clk_i) begin
    if (byte_en_i) begin
      unique case (pos_i)
        PosDeg:  deg_q  <= byte_i;
        PosMinA: mins_q <= GLD_MINS_W'(byte_i) * GLD_MINS_W'(GLD_MIN_SCALE_HI);
        PosMinB: mins_q <= mins_q + GLD_MINS_W'(byte_i) * GLD_MINS_W'(GLD_MIN_SCALE_LO);
        PosMinC: mins_q <= mins_q + GLD_MINS_W'(byte_i);
        PosFrac: frac_q <= prod[GLD_DIV3_SHIFT +: GLD_FRAC_W];
        default: ;
      endcase
    end
  end

  assign coord_o = GLD_COORD_W'(deg_q) * GLD_COORD_W'(GLD_USEC_PER_DEG)
                 + GLD_COORD_W'(frac_q);

endmodule

`default_nettype wire

// ===== src/gld_out_stage.sv =====
// ----------------------------------------------------------------------------
// gld_out_stage
// result register with a skid entry behind it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gld_out_stage (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 push_i,
  input  var gld_pkg::gld_result_t push_data_i,
  output var logic                 ready_o,
  output var logic                 out_valid_o,
  input  var logic                 out_ready_i,
  output var gld_pkg::gld_result_t out_data_o
);
  import gld_pkg::*;

  logic        out_vld_q, out_vld_d;
  logic        skid_vld_q, skid_vld_d;
  logic        load_out;
  gld_result_t out_q;
  gld_result_t skid_q;

  assign ready_o  = !skid_vld_q;
  assign load_out = !out_vld_q || out_ready_i;

  always_comb begin
    if (load_out) begin
      out_vld_d  = skid_vld_q || push_i;
      skid_vld_d = 1'b0;
    end else begin
      out_vld_d  = 1'b1;
      skid_vld_d = skid_vld_q || push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while result register empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("result pushed into a full output stage");

  a_held_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ready_i && skid_vld_q) |=> out_vld_q && !skid_vld_q)
    else $error("skid entry not moved into result register");

endmodule

`default_nettype wire

// ===== src/gps_log_record_deframer.sv =====
// ----------------------------------------------------------------------------
// gps_log_record_deframer
// frames 21-byte waypoint records out of a gps logger byte stream
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                         tuser
//  s_axis    in   data_byte[7:0]                stream_end
//  m_axis    out  hour..contacts, 137 bits      status[1:0]
//
//  one byte is taken every cycle while s_axis_tready_o is high; records,
//  spacers and the hunt run at that rate. a result enters the output stage
//  on the byte that causes it (checksum byte, offending byte or stream end).
//  reset clears the framing state to "expecting record or spacer start" and
//  empties the output stage; captured record fields are not reset.
//  the output stage holds two results, so s_axis keeps taking bytes while
//  one result waits; s_axis_tready_o drops only when both entries are full.
//  latitude and longitude are built up byte by byte as the record arrives,
//  one constant multiply per byte, so no step sees more than one multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gps_log_record_deframer #(
  parameter int unsigned SPACER_LEN = gld_pkg::GLD_SPACER_LEN_DEF
) (
  input  var logic         clk_i,
  input  var logic         rst_ni,
  // input byte stream
  input  var logic         s_axis_tvalid_i,
  output var logic         s_axis_tready_o,
  input  var logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  var logic         s_axis_tuser_i,   // [0] stream_end
  // result stream
  output var logic         m_axis_tvalid_o,
  input  var logic         m_axis_tready_i,
  // [7:0] hour, [15:8] minute, [23:16] second, [31:24] day, [39:32] month,
  // [51:40] year, [70:52] speed_milli_kmh, [99:71] lat_microdeg,
  // [128:100] lon_microdeg, [136:129] contacts, [143:137] zero
  output var logic [143:0] m_axis_tdata_o,
  output var logic [1:0]   m_axis_tuser_o    // [1:0] status
);
  import gld_pkg::*;

  localparam logic [GLD_POS_W-1:0] PosLast   = GLD_POS_W'(GLD_RECORD_LEN - 1);
  localparam logic [GLD_POS_W-1:0] PosHdrEnd = GLD_POS_W'(GLD_HDR_LEN);
  localparam logic [GLD_POS_W-1:0] PosClip   = GLD_POS_W'(GLD_HDR_LEN - 1);
  localparam logic [GLD_POS_W-1:0] SpacerEnd = GLD_POS_W'(SPACER_LEN);
  localparam logic [7:0]           HdrXor    = GLD_SYNC_A ^ GLD_SYNC_B ^ GLD_SYNC_A;

  // framing state
  gld_mode_e            mode_q, mode_d;
  logic [GLD_POS_W-1:0] pos_q, pos_d;
  logic [7:0]           xor_q, xor_d;
  logic [1:0]           hunt_q, hunt_d;

  // captured record fields
  logic [7:0]             hour_q, minute_q, second_q, day_q, month_q, contacts_q;
  logic [GLD_YEAR_W-1:0]  year_q;
  logic [GLD_SPEED_W-1:0] speed_q;
  logic [GLD_COORD_W-1:0] lat_coord, lon_coord;

  logic        in_fire, byte_fire, rec_byte_en;
  logic [7:0]  b;
  logic [1:0]  start_idx;
  logic        start_match, rec_hdr_bad, rec_at_last, chk_ok;
  logic [GLD_POS_W-1:0] pos_inc;

  logic        res_fire;
  gld_result_t res;
  gld_result_t out_res;
  logic        out_ready;

  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_fire   = in_fire && !s_axis_tuser_i;
  assign b           = s_axis_tdata_i;
  assign rec_byte_en = byte_fire && (mode_q == MODE_RECORD);

  // shared decode of the current byte
  assign start_idx   = (pos_q > PosClip) ? PosClip[1:0] : pos_q[1:0];
  assign start_match = (b == gld_hdr_byte(start_idx));
  assign rec_hdr_bad = (pos_q < PosHdrEnd) && (b != gld_hdr_byte(pos_q[1:0]));
  assign rec_at_last = (pos_q >= PosLast);
  assign chk_ok      = (xor_q == b);
  assign pos_inc     = pos_q + GLD_POS_W'(1);

  // next framing state
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    xor_d  = xor_q;
    hunt_d = hunt_q;
    if (in_fire) begin
      if (s_axis_tuser_i) begin
        // stream end drops any partial record or spacer
        mode_d = MODE_START;
        pos_d  = '0;
        xor_d  = '0;
        hunt_d = '0;
      end else begin
        unique case (mode_q)
          MODE_START: begin
            if (start_match) begin
              xor_d = xor_q ^ b;
              pos_d = GLD_POS_W'(start_idx) + GLD_POS_W'(1);
              if (start_idx == PosClip[1:0]) begin
                mode_d = MODE_RECORD;
              end
            end else if (start_idx == 2'd0) begin
              // not a 255: framing error, start hunting
              mode_d = MODE_HUNT;
              pos_d  = '0;
              xor_d  = '0;
              hunt_d = '0;
            end else begin
              // 255 followed by a header break: this is a spacer
              xor_d = '0;
              if (GLD_POS_W'(start_idx) + GLD_POS_W'(1) >= SpacerEnd) begin
                mode_d = MODE_RECORD;
                pos_d  = '0;
              end else begin
                mode_d = MODE_SPACER;
                pos_d  = GLD_POS_W'(start_idx) + GLD_POS_W'(1);
              end
            end
          end
          MODE_SPACER: begin
            if (pos_inc >= SpacerEnd) begin
              mode_d = MODE_RECORD;
              pos_d  = '0;
              xor_d  = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          MODE_RECORD: begin
            if (rec_hdr_bad) begin
              // a 255 here already counts as the first header byte
              mode_d = MODE_HUNT;
              pos_d  = '0;
              xor_d  = '0;
              hunt_d = (b == GLD_SYNC_A) ? 2'd1 : 2'd0;
            end else if (!rec_at_last) begin
              xor_d = xor_q ^ b;
              pos_d = pos_inc;
            end else if (!chk_ok) begin
              mode_d = MODE_HUNT;
              pos_d  = '0;
              xor_d  = '0;
              hunt_d = '0;
            end else begin
              mode_d = MODE_START;
              pos_d  = '0;
              xor_d  = '0;
            end
          end
          MODE_HUNT: begin
            if (hunt_q >= 2'd2 && b == GLD_SYNC_A) begin
              // header found: carry on as record byte 3
              mode_d = MODE_RECORD;
              pos_d  = PosHdrEnd;
              xor_d  = HdrXor;
              hunt_d = '0;
            end else if (b == GLD_SYNC_A) begin
              hunt_d = 2'd1;
            end else if (hunt_q == 2'd1 && b == GLD_SYNC_B) begin
              hunt_d = 2'd2;
            end else begin
              hunt_d = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result of the current transaction
  always_comb begin
    res_fire = 1'b0;
    res      = '0;
    if (in_fire) begin
      if (s_axis_tuser_i) begin
        res_fire   = 1'b1;
        res.status = GLD_ST_END;
      end else begin
        unique case (mode_q)
          MODE_START: begin
            if (!start_match && start_idx == 2'd0) begin
              res_fire   = 1'b1;
              res.status = GLD_ST_FRAMING;
            end
          end
          MODE_RECORD: begin
            if (rec_hdr_bad) begin
              res_fire   = 1'b1;
              res.status = GLD_ST_FRAMING;
            end else if (rec_at_last && !chk_ok) begin
              res_fire   = 1'b1;
              res.status = GLD_ST_CHECKSUM;
            end else if (rec_at_last) begin
              res_fire            = 1'b1;
              res.status          = GLD_ST_OK;
              res.hour            = hour_q;
              res.minute          = minute_q;
              res.second          = second_q;
              res.day             = day_q;
              res.month           = month_q;
              res.year            = year_q;
              res.speed_milli_kmh = speed_q;
              res.lat_microdeg    = lat_coord;
              res.lon_microdeg    = lon_coord;
              res.contacts        = contacts_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      pos_q  <= '0;
      xor_q  <= '0;
      hunt_q <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      hunt_q <= hunt_d;
    end
  end

  // plain record fields, with year offset and knot scaling done on arrival
  always_ff @(posedge clk_i) begin
    if (rec_byte_en) begin
      unique case (pos_q)
        GLD_POS_W'(GLD_POS_HOUR):     hour_q     <= b;
        GLD_POS_W'(GLD_POS_MINUTE):   minute_q   <= b;
        GLD_POS_W'(GLD_POS_SECOND):   second_q   <= b;
        GLD_POS_W'(GLD_POS_DAY):      day_q      <= b;
        GLD_POS_W'(GLD_POS_MONTH):    month_q    <= b;
        GLD_POS_W'(GLD_POS_YEAR):
          year_q <= GLD_YEAR_W'(GLD_YEAR_BASE) + GLD_YEAR_W'(b);
        GLD_POS_W'(GLD_POS_SPEED):
          speed_q <= GLD_SPEED_W'(b) * GLD_SPEED_W'(GLD_KNOT_MILLI);
        GLD_POS_W'(GLD_POS_CONTACTS): contacts_q <= b;
        default: ;
      endcase
    end
  end

  gld_coord #(
    .DEG_POS (GLD_POS_LAT)
  ) u_lat (
    .clk_i     (clk_i),
    .byte_en_i (rec_byte_en),
    .pos_i     (pos_q),
    .byte_i    (b),
    .coord_o   (lat_coord)
  );

  gld_coord #(
    .DEG_POS (GLD_POS_LON)
  ) u_lon (
    .clk_i     (clk_i),
    .byte_en_i (rec_byte_en),
    .pos_i     (pos_q),
    .byte_i    (b),
    .coord_o   (lon_coord)
  );

  gld_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_fire),
    .push_data_i (res),
    .ready_o     (out_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign s_axis_tready_o = out_ready;
  assign m_axis_tuser_o  = out_res.status;
  assign m_axis_tdata_o  = {7'd0, out_res.contacts, out_res.lon_microdeg,
                            out_res.lat_microdeg, out_res.speed_milli_kmh,
                            out_res.year, out_res.month, out_res.day,
                            out_res.second, out_res.minute, out_res.hour};

  a_record_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RECORD) |-> (pos_q <= PosLast))
    else $error("record position past checksum byte");

  a_start_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_START) |-> (pos_q <= PosClip))
    else $error("start position past header");

  a_spacer_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SPACER) |-> (pos_q != '0 && pos_q < SpacerEnd))
    else $error("spacer position out of range");

  a_hunt_clear_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RECORD && pos_q == PosHdrEnd && $past(mode_q) == MODE_HUNT)
      |-> (xor_q == HdrXor && hunt_q == 2'd0))
    else $error("record entered from hunt with stale checksum");

endmodule

`default_nettype wire
